>>> rtl/bgcs_pkg.sv
package bgcs_pkg;

  localparam int MAX_GRID = 8;
  localparam int ROW_W    = 8;
  localparam int CELLS    = MAX_GRID * MAX_GRID;
  localparam int CELL_W   = 6;
  localparam int SLOTS    = 32;
  localparam int SLOT_W   = 5;
  localparam int SIZE_W   = 7;
  localparam int CNT_W    = 6;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_SIZE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_NB,
    ST_INS_RD,
    ST_INS_CMP,
    ST_EMIT_CNT,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

endpackage

>>> rtl/bgcs_ram.sv
module bgcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/binary_grid_component_sizer_unit.sv
// Binary grid component sizer.
// Input channel: row_bits with in_valid/in_ready, one grid row per item,
// bit j is column j. Config: cfg_we/cfg_data write grid_size (0 acts as 1,
// above 8 acts as 8); write only while idle.
// Rows that do not complete the grid are stored as they arrive. The row
// that completes the grid starts a labeling pass: a scan of all 64 cell
// positions, plus a pop step and four neighbor steps per occupied cell
// for the breadth-first fill (one neighbor test per cycle in a shared
// checker), plus a read and a compare step per shifted entry of the
// insertion sort of region sizes.
// Output channel: kind/value/last with out_valid/out_ready. First item is
// the region count, then each region size in ascending order; last marks
// the final item. The output register lets the pass run ahead by one item;
// if the receiver stalls, the sequencer waits. in_ready stays low from the
// completing row until the last item has been loaded in the output register.
// Reset (synchronous, rst high) clears the grid, visited map, row counter
// and sets grid_size to 8. Queue and size list need no clearing.
module binary_grid_component_sizer_unit
  import bgcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ROW_W-1:0]  row_bits,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_data,
  output logic              kind,
  output logic [SIZE_W-1:0] value,
  output logic              last,
  output logic              out_valid,
  input  logic              out_ready
);

  state_t state, state_next;

  logic [3:0]        grid_size;
  logic [3:0]        n;
  logic [CELLS-1:0]  grid;
  logic [CELLS-1:0]  visited;
  logic [3:0]        rows_loaded;
  logic [CNT_W-1:0]  region_count;
  logic [CELL_W:0]   scan;
  logic [CELL_W:0]   head;
  logic [CELL_W:0]   tail;
  logic [CELL_W:0]   tail_next;
  logic [1:0]        dir;
  logic [SIZE_W-1:0] size;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  pos_m1;
  logic [CNT_W-1:0]  k;

  logic              q_we;
  logic [CELL_W-1:0] q_waddr;
  logic [CELL_W-1:0] q_wdata;
  logic [CELL_W-1:0] q_rdata;

  logic              s_we;
  logic [SLOT_W-1:0] s_waddr;
  logic [SIZE_W-1:0] s_wdata;
  logic [SLOT_W-1:0] s_raddr;
  logic [SIZE_W-1:0] s_rdata;

  logic              accept;
  logic              grid_done;
  logic              slot_free;
  logic [CELL_W-1:0] scan_idx;
  logic              scan_hit;
  logic [3:0]        cr, cc, nr, nc;
  logic              nb_ok;
  logic [CELL_W-1:0] nb_idx;
  logic              nb_take;
  logic              ins_shift;
  logic              emit_last;

  assign n = (grid_size == 4'd0) ? 4'd1 :
             (grid_size > 4'(MAX_GRID)) ? 4'(MAX_GRID) : grid_size;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign grid_done = (rows_loaded + 4'd1) >= n;
  assign slot_free = !out_valid || out_ready;

  assign scan_idx = scan[CELL_W-1:0];
  assign scan_hit = ({1'b0, scan_idx[5:3]} < n) && ({1'b0, scan_idx[2:0]} < n)
                    && grid[scan_idx] && !visited[scan_idx];

  // neighbor checker
  always_comb begin
    cr = {1'b0, q_rdata[5:3]};
    cc = {1'b0, q_rdata[2:0]};
    nr = cr;
    nc = cc;
    nb_ok = 1'b0;
    case (dir)
      DIR_LEFT: begin
        nc = cc - 4'd1;
        nb_ok = (cc != 4'd0);
      end
      DIR_RIGHT: begin
        nc = cc + 4'd1;
        nb_ok = (nc < n);
      end
      DIR_UP: begin
        nr = cr - 4'd1;
        nb_ok = (cr != 4'd0);
      end
      default: begin
        nr = cr + 4'd1;
        nb_ok = (nr < n);
      end
    endcase
  end

  assign nb_idx    = {nr[2:0], nc[2:0]};
  assign nb_take   = nb_ok && grid[nb_idx] && !visited[nb_idx];
  assign tail_next = tail + ((state == ST_NB && nb_take) ? 7'd1 : 7'd0);
  assign pos_m1    = pos - 6'd1;
  assign ins_shift = (s_rdata > size);
  assign emit_last = (k + 6'd1) == region_count;

  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail[CELL_W-1:0];
    q_wdata = nb_idx;
    if (state == ST_SCAN && !scan[CELL_W] && scan_hit) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = scan_idx;
    end else if (state == ST_NB && nb_take) begin
      q_we = 1'b1;
    end
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = pos[SLOT_W-1:0];
    s_wdata = size;
    s_raddr = pos_m1[SLOT_W-1:0];
    case (state)
      ST_INS_RD: begin
        s_we = (pos == '0);
      end
      ST_INS_CMP: begin
        s_we = 1'b1;
        if (ins_shift) begin
          s_wdata = s_rdata;
        end
      end
      ST_EMIT_CNT, ST_EMIT_RD, ST_EMIT_WR: begin
        s_raddr = k[SLOT_W-1:0];
      end
      default: ;
    endcase
  end

  bgcs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head[CELL_W-1:0]),
    .rdata (q_rdata)
  );

  bgcs_ram #(.WIDTH(SIZE_W), .DEPTH(SLOTS)) u_sizes (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && grid_done) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan[CELL_W])  state_next = ST_EMIT_CNT;
        else if (scan_hit) state_next = ST_POP;
      end
      ST_POP: state_next = ST_NB;
      ST_NB: begin
        if (dir == DIR_DOWN) begin
          state_next = ((head + 7'd1) == tail_next) ? ST_INS_RD : ST_POP;
        end
      end
      ST_INS_RD: begin
        state_next = (pos == '0) ? ST_SCAN : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_next = ins_shift ? ST_INS_RD : ST_SCAN;
      end
      ST_EMIT_CNT: begin
        if (slot_free) state_next = (region_count == '0) ? ST_IDLE : ST_EMIT_RD;
      end
      ST_EMIT_RD: state_next = ST_EMIT_WR;
      ST_EMIT_WR: begin
        if (slot_free) state_next = emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size    <= 4'(MAX_GRID);
      grid         <= '0;
      visited      <= '0;
      rows_loaded  <= '0;
      region_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        grid_size <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            grid[{rows_loaded[2:0], 3'b000} +: ROW_W] <= row_bits;
            if (grid_done) begin
              rows_loaded  <= '0;
              visited      <= '0;
              region_count <= '0;
              scan         <= '0;
            end else begin
              rows_loaded <= rows_loaded + 4'd1;
            end
          end
        end
        ST_SCAN: begin
          if (!scan[CELL_W]) begin
            if (scan_hit) begin
              visited[scan_idx] <= 1'b1;
              head <= '0;
              tail <= 7'd1;
              size <= 7'd1;
            end else begin
              scan <= scan + 7'd1;
            end
          end
        end
        ST_POP: dir <= DIR_LEFT;
        ST_NB: begin
          if (nb_take) begin
            visited[nb_idx] <= 1'b1;
            size <= size + 7'd1;
          end
          tail <= tail_next;
          dir  <= dir + 2'd1;
          if (dir == DIR_DOWN) begin
            head <= head + 7'd1;
            pos  <= region_count;
          end
        end
        ST_INS_RD: begin
          if (pos == '0) begin
            region_count <= region_count + 6'd1;
            scan         <= scan + 7'd1;
          end
        end
        ST_INS_CMP: begin
          if (ins_shift) begin
            pos <= pos_m1;
          end else begin
            region_count <= region_count + 6'd1;
            scan         <= scan + 7'd1;
          end
        end
        ST_EMIT_CNT: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            kind      <= KIND_COUNT;
            value     <= {1'b0, region_count};
            last      <= (region_count == '0);
            k         <= '0;
          end
        end
        ST_EMIT_WR: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            kind      <= KIND_SIZE;
            value     <= s_rdata;
            last      <= emit_last;
            k         <= k + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NB) |-> (head < tail))
    else $error("queue head passed tail");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    region_count <= 6'(SLOTS))
    else $error("region count out of range");

  a_busy_after_grid: assert property (@(posedge clk) disable iff (rst)
    (accept && grid_done) |=> !in_ready)
    else $error("ready right after completing row");

  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NB) |-> (size <= 7'(CELLS)))
    else $error("region size out of range");

endmodule

>>> tb/tb_binary_grid_component_sizer_unit.sv
`timescale 1ns / 100ps

module tb_binary_grid_component_sizer_unit
  import bgcs_pkg::*;
();

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] value;
    logic              last;
  } region_item_t;

  typedef struct {
    logic             is_cfg;
    logic [3:0]       cfg_val;
    logic [ROW_W-1:0] row;
    int               n_exp;
    region_item_t     exp0;
  } grid_row_t;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 600;

  logic              clk;
  logic              rst;
  logic [ROW_W-1:0]  row_bits;
  logic              in_valid;
  logic              in_ready;
  logic              cfg_we;
  logic [3:0]        cfg_data;
  logic              kind;
  logic [SIZE_W-1:0] value;
  logic              last;
  logic              out_valid;
  logic              out_ready;

  binary_grid_component_sizer_unit uut (
    .clk(clk), .rst(rst), .row_bits(row_bits), .in_valid(in_valid),
    .in_ready(in_ready), .cfg_we(cfg_we), .cfg_data(cfg_data), .kind(kind),
    .value(value), .last(last), .out_valid(out_valid), .out_ready(out_ready)
  );

  logic [3:0]       size_reg;
  logic [ROW_W-1:0] pend_rows[MAX_GRID];
  int               rows_in;
  region_item_t     exp_items[$];
  int               mismatches;
  int               cycles;
  logic             in_idle_on;
  logic             out_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // labels the stored grid and queues count plus sorted sizes
  task automatic label_grid(input int n);
    logic [MAX_GRID-1:0] seen[MAX_GRID];
    int sizes[$];
    int qr[$];
    int qc[$];
    int r, c, d, nr, nc, cnt, cr, cc;
    region_item_t it;
    for (r = 0; r < MAX_GRID; r++) seen[r] = '0;
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++)
        if (pend_rows[r][c] && !seen[r][c]) begin
          cnt = 1;
          seen[r][c] = 1'b1;
          qr.push_back(r);
          qc.push_back(c);
          while (qr.size() > 0) begin
            cr = qr.pop_front();
            cc = qc.pop_front();
            for (d = 0; d < 4; d++) begin
              nr = cr + (d == 2 ? -1 : d == 3 ? 1 : 0);
              nc = cc + (d == 0 ? -1 : d == 1 ? 1 : 0);
              if (nr >= 0 && nc >= 0 && nr < n && nc < n && pend_rows[nr][nc] &&
                  !seen[nr][nc]) begin
                seen[nr][nc] = 1'b1;
                qr.push_back(nr);
                qc.push_back(nc);
                cnt++;
              end
            end
          end
          sizes.push_back(cnt);
        end
    sizes.sort();
    it.kind  = KIND_COUNT;
    it.value = 7'(sizes.size());
    it.last  = (sizes.size() == 0);
    exp_items.push_back(it);
    for (int k = 0; k < sizes.size(); k++) begin
      it.kind  = KIND_SIZE;
      it.value = 7'(sizes[k]);
      it.last  = (k == sizes.size() - 1);
      exp_items.push_back(it);
    end
  endtask

  task automatic predict_row(input logic [ROW_W-1:0] rb);
    int n;
    n = (size_reg < 1) ? 1 : (size_reg > MAX_GRID) ? MAX_GRID : size_reg;
    if (rows_in < MAX_GRID) pend_rows[rows_in] = rb;
    if (rows_in + 1 < n) begin
      rows_in++;
    end else begin
      rows_in = 0;
      label_grid(n);
    end
  endtask

  task automatic send_row(input logic [ROW_W-1:0] rb);
    @(negedge clk);
    while (in_idle_on && ($urandom_range(99) < 29)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    row_bits <= rb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_row(rb);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (exp_items.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_size(input logic [3:0] v);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    size_reg = v;
  endtask

  // output checker
  always @(posedge clk) begin
    region_item_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{kind, value, last};
      if (exp_items.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item %p", got);
      end else begin
        want = exp_items.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  always @(negedge clk) out_ready <= !(out_idle_on && ($urandom_range(99) < 29));

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    grid_row_t dir_rows[$];
    grid_row_t g;
    logic [3:0] sz;
    int nrows;
    mismatches = 0;
    cycles = 0;
    rows_in = 0;
    size_reg = 4'd8;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    rst = 1'b1;
    row_bits = '0;
    in_valid = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 4'd0;
    out_ready = 1'b1;
    for (int r = 0; r < MAX_GRID; r++) pend_rows[r] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty 8x8, full 8x8, checkerboard, size extremes
    for (int r = 0; r < 8; r++)
      dir_rows.push_back('{1'b0, 4'd0, 8'h00, r == 7 ? 1 : 0, '{KIND_COUNT, 7'd0, 1'b1}});
    for (int r = 0; r < 8; r++)
      dir_rows.push_back('{1'b0, 4'd0, 8'hFF, r == 7 ? 2 : 0, '{KIND_COUNT, 7'd1, 1'b0}});
    for (int r = 0; r < 8; r++)
      dir_rows.push_back('{1'b0, 4'd0, (r % 2) ? 8'hAA : 8'h55, r == 7 ? 33 : 0,
                           '{KIND_COUNT, 7'd32, 1'b0}});
    dir_rows.push_back('{1'b1, 4'd0, 8'h00, 0, '{KIND_COUNT, 7'd0, 1'b0}});
    dir_rows.push_back('{1'b0, 4'd0, 8'hFE, 1, '{KIND_COUNT, 7'd0, 1'b1}});
    dir_rows.push_back('{1'b0, 4'd0, 8'h01, 2, '{KIND_COUNT, 7'd1, 1'b0}});
    dir_rows.push_back('{1'b1, 4'd15, 8'h00, 0, '{KIND_COUNT, 7'd0, 1'b0}});
    dir_rows.push_back('{1'b1, 4'd2, 8'h00, 0, '{KIND_COUNT, 7'd0, 1'b0}});
    dir_rows.push_back('{1'b0, 4'd0, 8'hFD, 0, '{KIND_COUNT, 7'd0, 1'b0}});
    dir_rows.push_back('{1'b0, 4'd0, 8'h02, 3, '{KIND_COUNT, 7'd2, 1'b0}});

    foreach (dir_rows[i]) begin
      g = dir_rows[i];
      if (g.is_cfg) begin
        write_size(g.cfg_val);
      end else begin
        if (g.n_exp > 0) drain_results();
        send_row(g.row);
        if (g.n_exp > 0) begin
          if (exp_items.size() != g.n_exp || exp_items[0] !== g.exp0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("row %0d: expected %0d items, first %p; predicted %0d, %p",
                       i, g.n_exp, g.exp0, exp_items.size(), exp_items[0]);
          end
        end
      end
    end

    // random grids, resizing between some of them
    write_size(4'd8);
    nrows = 0;
    while (nrows < 200) begin
      if ($urandom_range(9) == 0 && rows_in == 0) begin
        sz = 4'($urandom_range(15));
        write_size(sz);
      end
      if (nrows == 60) drain_results();
      in_idle_on  = !(nrows >= 100 && nrows < 140);
      out_idle_on = in_idle_on;
      case ($urandom_range(3))
        0:       send_row(8'($urandom_range(255)));
        1:       send_row(8'($urandom_range(255) & $urandom_range(255)));
        2:       send_row(8'($urandom_range(255) | $urandom_range(255)));
        default: send_row($urandom_range(1) ? 8'hFF : 8'h00);
      endcase
      nrows++;
    end
    // close any partial grid so its result is predicted and checked
    while (rows_in != 0) send_row(8'($urandom_range(255)));

    drain_results();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
